// ----- rtl/ac97_pkg.sv -----
// Shared types, register codes and codec defaults for the AC97 register block.
`default_nettype none
package ac97_pkg;

  localparam int unsigned CODEC_WORDS = 64;
  localparam int unsigned CODEC_IDX_W = $clog2(CODEC_WORDS);

  localparam logic [15:0] RATE_MIN     = 16'd4000;
  localparam logic [15:0] RATE_MAX     = 16'd48000;
  localparam logic [31:0] VERSION_WORD = 32'h0000_0100;
  localparam logic [4:0]  KSTAT_FIXED  = 5'h03;
  localparam int unsigned RX_READY_BIT = 4;
  localparam int unsigned END_TX_BIT   = 10;
  localparam int unsigned END_RX_BIT   = 14;

  // Codec word indexes (byte address / 2) with special handling.
  localparam logic [CODEC_IDX_W-1:0] IDX_RESET = 6'h00;
  localparam logic [CODEC_IDX_W-1:0] IDX_PD    = 6'h13;
  localparam logic [CODEC_IDX_W-1:0] IDX_EXTID = 6'h14;
  localparam logic [CODEC_IDX_W-1:0] IDX_DAC   = 6'h16;
  localparam logic [CODEC_IDX_W-1:0] IDX_ADC   = 6'h19;
  localparam logic [CODEC_IDX_W-1:0] IDX_VID1  = 6'h3e;
  localparam logic [CODEC_IDX_W-1:0] IDX_VID2  = 6'h3f;

  localparam logic [15:0] PD_DEFAULT = 16'h000f;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_PLAY  = 2'd2,
    KIND_CAPT  = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    REG_NONE, REG_MODE, REG_ISLOT, REG_OSLOT, REG_CSTAT, REG_CMODE,
    REG_KRX, REG_KTX, REG_KSTAT, REG_KMODE, REG_STAT, REG_IEN, REG_IDIS,
    REG_IMASK, REG_VER, REG_RP, REG_RC, REG_TP, REG_TC, REG_RNP, REG_RNC,
    REG_TNP, REG_TNC, REG_XCTL, REG_XSTAT
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    kind_e       kind;
    reg_e        rsel;
    logic [31:0] data;
    logic [15:0] bytes;
  } item_t;

  // Result beat layout, last member in the lowest bits.
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] adc_rate;
    logic [15:0] dac_rate;
    logic [15:0] dma_length;
    logic [31:0] dma_address;
    logic        capture_on;
    logic        playback_on;
    logic        irq_line;
    logic [31:0] read_data;
  } result_t;

  function automatic logic [15:0] codec_default(input logic [CODEC_IDX_W-1:0] idx);
    logic [15:0] v;
    v = 16'h0000;
    unique case (idx)
      6'h00:                      v = 16'h0d50;
      6'h01, 6'h06, 6'h07:        v = 16'h8008;
      6'h02, 6'h03, 6'h0e:        v = 16'h8000;
      6'h08, 6'h09, 6'h0a,
      6'h0b, 6'h0c:               v = 16'h8808;
      6'h11:                      v = 16'h0101;
      6'h13:                      v = PD_DEFAULT;
      6'h14:                      v = 16'h0001;
      6'h16, 6'h19:               v = RATE_MAX;
      6'h3e:                      v = 16'h4e53;
      6'h3f:                      v = 16'h4331;
      default:                    v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ac97_front.sv -----
// Front end: takes input beats and decodes the register offset.
`default_nettype none
module ac97_front (
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [8:0]         offset_i,
  input  logic [31:0]        data_i,
  input  logic [15:0]        bytes_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output ac97_pkg::item_t    q_item_o
);
  import ac97_pkg::*;

  reg_e rsel;

  always_comb begin
    unique case (offset_i)
      9'h008:  rsel = REG_MODE;
      9'h010:  rsel = REG_ISLOT;
      9'h014:  rsel = REG_OSLOT;
      9'h028:  rsel = REG_CSTAT;
      9'h02c:  rsel = REG_CMODE;
      9'h040:  rsel = REG_KRX;
      9'h044:  rsel = REG_KTX;
      9'h048:  rsel = REG_KSTAT;
      9'h04c:  rsel = REG_KMODE;
      9'h050:  rsel = REG_STAT;
      9'h054:  rsel = REG_IEN;
      9'h058:  rsel = REG_IDIS;
      9'h05c:  rsel = REG_IMASK;
      9'h0fc:  rsel = REG_VER;
      9'h100:  rsel = REG_RP;
      9'h104:  rsel = REG_RC;
      9'h108:  rsel = REG_TP;
      9'h10c:  rsel = REG_TC;
      9'h110:  rsel = REG_RNP;
      9'h114:  rsel = REG_RNC;
      9'h118:  rsel = REG_TNP;
      9'h11c:  rsel = REG_TNC;
      9'h120:  rsel = REG_XCTL;
      9'h124:  rsel = REG_XSTAT;
      default: rsel = REG_NONE;
    endcase
  end

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;
  assign q_item_o  = '{kind: kind_e'(mode_i), rsel: rsel, data: data_i, bytes: bytes_i};

endmodule
`default_nettype wire

// ----- rtl/ac97_queue.sv -----
// Two-entry queue of decoded items between front and back end.
`default_nettype none
module ac97_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ac97_pkg::item_t item_i,
  input  logic            pop_i,
  output ac97_pkg::item_t item_o,
  output logic            full_o,
  output logic            empty_o
);
  import ac97_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ac97_back.sv -----
// Back end: register file, codec store, DMA windows and result register.
`default_nettype none
module ac97_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ac97_pkg::item_t   item_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ac97_pkg::result_t out_o
);
  import ac97_pkg::*;

  state_e state_q, state_d;
  logic   go, finish;

  logic [2:0]  ctrl_q, ctrl_d;
  logic [31:0] islot_q, islot_d, oslot_q, oslot_d;
  logic [14:0] cstat_q, cstat_d;
  logic [31:0] cmode_q, cmode_d;
  logic [15:0] hold_q, hold_d;
  logic [4:0]  kstat_q, kstat_d;
  logic [31:0] kmode_q, kmode_d, imask_q, imask_d;
  logic [31:0] rp_q, rp_d, rc_q, rc_d, tp_q, tp_d, tc_q, tc_d;
  logic [31:0] rnp_q, rnp_d, rnc_q, rnc_d, tnp_q, tnp_d, tnc_q, tnc_d;
  logic        rxen_q, rxen_d, txen_q, txen_d;
  logic [15:0] pd_q, pd_d, dac_q, dac_d, adc_q, adc_d;
  logic [CODEC_WORDS-1:0] cvalid_q, cvalid_d;
  logic        hload_q, hload_d;
  logic [CODEC_IDX_W-1:0] ridx_q, ridx_d;
  logic [31:0] rdata_q, rdata_d, addr_q, addr_d;
  logic [15:0] len_q, len_d;
  logic        ovalid_q, ovalid_d;
  result_t     out_q, out_d;

  logic [15:0] mem_q [CODEC_WORDS];
  logic [15:0] mem_rd_q;
  logic        mem_we;

  // Transfer datapath.
  logic        is_play, chan_ok, chan_on, do_xfer;
  logic [31:0] cur_ptr, cur_cnt, cur_nptr, cur_ncnt;
  logic [31:0] new_ptr, new_cnt, new_nptr, new_ncnt;
  logic [15:0] even, lim, moved;
  logic        win_end;

  logic [CODEC_IDX_W-1:0] cidx;
  logic        rate_ok, irq_now;
  logic [15:0] hold_val;

  assign cidx    = item_i.data[22:17];
  assign rate_ok = (item_i.data[15:0] >= RATE_MIN) && (item_i.data[15:0] <= RATE_MAX);
  assign irq_now = ((|(cstat_q & cmode_q[14:0])) && imask_q[3]) ||
                   ((|(kstat_q & kmode_q[4:0])) && imask_q[2]);
  assign chan_ok = ctrl_q[0] && (cmode_q[22:21] == 2'b11);

  assign is_play  = (item_i.kind == KIND_PLAY);
  assign cur_ptr  = is_play ? tp_q  : rp_q;
  assign cur_cnt  = is_play ? tc_q  : rc_q;
  assign cur_nptr = is_play ? tnp_q : rnp_q;
  assign cur_ncnt = is_play ? tnc_q : rnc_q;
  assign chan_on  = chan_ok && (is_play ? txen_q : rxen_q);
  assign even     = {item_i.bytes[15:1], 1'b0};
  assign lim      = {cur_cnt[14:0], 1'b0};
  assign moved    = ((cur_cnt[31:15] != 17'd0) || (even <= lim)) ? even : lim;
  assign do_xfer  = (item_i.kind == KIND_PLAY || item_i.kind == KIND_CAPT) &&
                    chan_on && (moved != 16'd0);

  always_comb begin
    new_ptr  = cur_ptr + {16'd0, moved};
    new_cnt  = cur_cnt - {17'd0, moved[15:1]};
    new_nptr = cur_nptr;
    new_ncnt = cur_ncnt;
    win_end  = (new_cnt == 32'd0);
    if (win_end && (cur_ncnt != 32'd0)) begin
      new_ptr  = cur_nptr;
      new_cnt  = cur_ncnt;
      new_nptr = 32'd0;
      new_ncnt = 32'd0;
    end
  end

  // Value of a codec read, resolved once the store read has landed.
  always_comb begin
    if (ridx_q == IDX_PD) begin
      hold_val = pd_q;
    end else if (ridx_q == IDX_DAC) begin
      hold_val = dac_q;
    end else if (ridx_q == IDX_ADC) begin
      hold_val = adc_q;
    end else if (cvalid_q[ridx_q]) begin
      hold_val = mem_rd_q;
    end else begin
      hold_val = codec_default(ridx_q);
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (!q_empty_i && !ovalid_q) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    go     = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      ST_IDLE:   go = !q_empty_i && !ovalid_q;
      ST_FINISH: finish = 1'b1;
      default:   go = 1'b0;
    endcase
  end

  assign q_pop_o = go;

  always_comb begin
    ctrl_d = ctrl_q;   islot_d = islot_q; oslot_d = oslot_q; cstat_d = cstat_q;
    cmode_d = cmode_q; hold_d = hold_q;   kstat_d = kstat_q; kmode_d = kmode_q;
    imask_d = imask_q; rp_d = rp_q; rc_d = rc_q; tp_d = tp_q; tc_d = tc_q;
    rnp_d = rnp_q; rnc_d = rnc_q; tnp_d = tnp_q; tnc_d = tnc_q;
    rxen_d = rxen_q; txen_d = txen_q; pd_d = pd_q; dac_d = dac_q; adc_d = adc_q;
    cvalid_d = cvalid_q; hload_d = 1'b0; ridx_d = ridx_q;
    rdata_d = rdata_q; addr_d = addr_q; len_d = len_q;
    mem_we = 1'b0;
    ovalid_d = ovalid_q && !out_ready_i;
    out_d = out_q;

    if (go) begin
      rdata_d = 32'd0;
      addr_d  = 32'd0;
      len_d   = 16'd0;
      unique case (item_i.kind)
        KIND_READ: begin
          unique case (item_i.rsel)
            REG_MODE:  rdata_d = {29'd0, ctrl_q};
            REG_ISLOT: rdata_d = islot_q;
            REG_OSLOT: rdata_d = oslot_q;
            REG_CSTAT: begin
              rdata_d = {17'd0, cstat_q};
              cstat_d = 15'd0;
            end
            REG_CMODE: rdata_d = cmode_q;
            REG_KRX: begin
              rdata_d = {16'd0, hold_q};
              kstat_d[RX_READY_BIT] = 1'b0;
            end
            REG_KSTAT: rdata_d = {27'd0, kstat_q | KSTAT_FIXED};
            REG_KMODE: rdata_d = kmode_q;
            REG_STAT:  rdata_d = {28'd0, |(cstat_q & cmode_q[14:0]),
                                  |(kstat_q & kmode_q[4:0]), 2'b00};
            REG_IMASK: rdata_d = imask_q;
            REG_VER:   rdata_d = VERSION_WORD;
            REG_RP:    rdata_d = rp_q;
            REG_RC:    rdata_d = rc_q;
            REG_TP:    rdata_d = tp_q;
            REG_TC:    rdata_d = tc_q;
            REG_RNP:   rdata_d = rnp_q;
            REG_RNC:   rdata_d = rnc_q;
            REG_TNP:   rdata_d = tnp_q;
            REG_TNC:   rdata_d = tnc_q;
            REG_XSTAT: rdata_d = {23'd0, txen_q, 7'd0, rxen_q};
            default:   rdata_d = 32'd0;
          endcase
        end
        KIND_WRITE: begin
          unique case (item_i.rsel)
            REG_MODE: begin
              ctrl_d = item_i.data[2:0];
              if (item_i.data[1]) begin
                cvalid_d = '0;
                pd_d = PD_DEFAULT; dac_d = RATE_MAX; adc_d = RATE_MAX;
              end
            end
            REG_ISLOT: islot_d = item_i.data;
            REG_OSLOT: oslot_d = item_i.data;
            REG_CMODE: cmode_d = item_i.data;
            REG_KTX: begin
              if (item_i.data[23]) begin
                hload_d = 1'b1;
                ridx_d  = cidx;
                kstat_d[RX_READY_BIT] = 1'b1;
              end else if (cidx == IDX_RESET) begin
                cvalid_d = '0;
                pd_d = PD_DEFAULT; dac_d = RATE_MAX; adc_d = RATE_MAX;
              end else if (cidx == IDX_DAC) begin
                if (rate_ok) dac_d = item_i.data[15:0];
              end else if (cidx == IDX_ADC) begin
                if (rate_ok) adc_d = item_i.data[15:0];
              end else if (cidx == IDX_PD) begin
                pd_d = {item_i.data[15:4], pd_q[3:0]};
              end else if (cidx != IDX_EXTID && cidx != IDX_VID1 && cidx != IDX_VID2) begin
                mem_we = 1'b1;
                cvalid_d[cidx] = 1'b1;
              end
            end
            REG_KMODE: kmode_d = item_i.data;
            REG_IEN:   imask_d = imask_q | item_i.data;
            REG_IDIS:  imask_d = imask_q & ~item_i.data;
            REG_RP:    rp_d  = item_i.data;
            REG_RC:    rc_d  = item_i.data;
            REG_TP:    tp_d  = item_i.data;
            REG_TC:    tc_d  = item_i.data;
            REG_RNP:   rnp_d = item_i.data;
            REG_RNC:   rnc_d = item_i.data;
            REG_TNP:   tnp_d = item_i.data;
            REG_TNC:   tnc_d = item_i.data;
            REG_XCTL: begin
              if (item_i.data[0]) rxen_d = 1'b1;
              if (item_i.data[1]) rxen_d = 1'b0;
              if (item_i.data[8]) txen_d = 1'b1;
              if (item_i.data[9]) txen_d = 1'b0;
            end
            default: ;
          endcase
        end
        default: begin
          if (do_xfer) begin
            addr_d = cur_ptr;
            len_d  = moved;
            if (is_play) begin
              tp_d = new_ptr; tc_d = new_cnt; tnp_d = new_nptr; tnc_d = new_ncnt;
              if (win_end) cstat_d[END_TX_BIT] = 1'b1;
            end else begin
              rp_d = new_ptr; rc_d = new_cnt; rnp_d = new_nptr; rnc_d = new_ncnt;
              if (win_end) cstat_d[END_RX_BIT] = 1'b1;
            end
          end
        end
      endcase
    end

    if (finish) begin
      if (hload_q) hold_d = hold_val;
      ovalid_d = 1'b1;
      out_d = '{pad: 5'd0, adc_rate: adc_q, dac_rate: dac_q, dma_length: len_q,
                dma_address: addr_q, capture_on: chan_ok && rxen_q,
                playback_on: chan_ok && txen_q, irq_line: irq_now, read_data: rdata_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ctrl_q <= '0; islot_q <= '0; oslot_q <= '0; cstat_q <= '0; cmode_q <= '0;
      hold_q <= '0; kstat_q <= KSTAT_FIXED; kmode_q <= '0; imask_q <= '0;
      rp_q <= '0; rc_q <= '0; tp_q <= '0; tc_q <= '0;
      rnp_q <= '0; rnc_q <= '0; tnp_q <= '0; tnc_q <= '0;
      rxen_q <= 1'b0; txen_q <= 1'b0;
      pd_q <= PD_DEFAULT; dac_q <= RATE_MAX; adc_q <= RATE_MAX;
      cvalid_q <= '0; hload_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctrl_q <= ctrl_d; islot_q <= islot_d; oslot_q <= oslot_d; cstat_q <= cstat_d;
      cmode_q <= cmode_d; hold_q <= hold_d; kstat_q <= kstat_d; kmode_q <= kmode_d;
      imask_q <= imask_d;
      rp_q <= rp_d; rc_q <= rc_d; tp_q <= tp_d; tc_q <= tc_d;
      rnp_q <= rnp_d; rnc_q <= rnc_d; tnp_q <= tnp_d; tnc_q <= tnc_d;
      rxen_q <= rxen_d; txen_q <= txen_d;
      pd_q <= pd_d; dac_q <= dac_d; adc_q <= adc_d;
      cvalid_q <= cvalid_d; hload_q <= hload_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q  <= ridx_d;
    rdata_q <= rdata_d;
    addr_q  <= addr_d;
    len_q   <= len_d;
    out_q   <= out_d;
  end

  // Codec store: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cidx] <= item_i.data[15:0];
    end
    mem_rd_q <= mem_q[cidx];
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ----- rtl/ac97_controller_register_block.sv -----
// Top level of the AC97 controller register block with PDC-style DMA.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: mode; tdata: offset, write data, transfer bytes
//   m_axis    out        tdata: read data, irq, enables, DMA window, codec rates
//
// Each item passes through the back end in ST_IDLE, which executes the access
// or transfer against the register file and issues the codec store read, and
// then in ST_FINISH, which settles the codec read-back and loads the result
// register. A new item starts only once the result register is empty, so the
// back end takes no new item before the result beat of the last one is taken.
// The front end decodes offsets and fills a two-entry queue, so up to two input
// beats are taken while the back end works or the output stalls.
// Reset is asynchronous and active low; it restores the control, status and
// DMA registers and the codec defaults, but not the result register.
`default_nettype none
module ac97_controller_register_block (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [8:0] register_offset, [40:9] write_data, [56:41] transfer_bytes, rest zero
  input  logic [63:0]  s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] read_data, [32] irq_line, [33] playback_on, [34] capture_on,
  // [66:35] dma_address, [82:67] dma_length, [98:83] dac_rate,
  // [114:99] adc_rate, rest zero
  output logic [119:0] m_axis_tdata_o
);
  import ac97_pkg::*;

  logic    q_push, q_pop, q_full, q_empty;
  item_t   push_item, head_item;
  result_t result;

  ac97_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .mode_i    (s_axis_tuser_i),
    .offset_i  (s_axis_tdata_i[8:0]),
    .data_i    (s_axis_tdata_i[40:9]),
    .bytes_i   (s_axis_tdata_i[56:41]),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (push_item)
  );

  ac97_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ac97_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result)
  );

  assign m_axis_tdata_o = result;

endmodule
`default_nettype wire

// ----- rtl/ac97_checker.sv -----
// Port-level checks for the AC97 register block, bound to the top level.
`default_nettype none
module ac97_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [119:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_even_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[67])
    else $error("odd DMA length");

  a_no_len_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[82:67] == 16'd0) |-> (m_axis_tdata_o[66:35] == 32'd0))
    else $error("DMA address without a transfer");

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[98:83] >= 16'd4000) &&
                        (m_axis_tdata_o[98:83] <= 16'd48000) &&
                        (m_axis_tdata_o[114:99] >= 16'd4000) &&
                        (m_axis_tdata_o[114:99] <= 16'd48000))
    else $error("codec rate out of range");

endmodule

bind ac97_controller_register_block ac97_checker u_checker (.*);
`default_nettype wire
